// ===== hw/rtl/qtlc_pkg.sv =====
// Package: types, constants and tables for the quaternion tilt letter classifier.
package qtlc_pkg;

   localparam int AngleFracBitsDefault = 12;
   localparam int CordicStepsDefault   = 14;
   localparam int AtanTableLen         = 20;
   localparam int CfgWidth             = 15;
   localparam int CfgIndexWidth        = 3;
   localparam int AccWidth             = 40;
   localparam int VecWidth             = 40;
   localparam int SqrtRadWidth         = 58;
   localparam int SqrtRootWidth        = 29;
   localparam int SqrtSteps            = 29;

   localparam logic signed [AccWidth-1:0] PiQ30  = 40'sd3373259426;
   localparam logic signed [VecWidth-1:0] OneQ28 = 40'sd268435456;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_POSE   = 2'd1,
      KIND_REPORT = 2'd2,
      KIND_UNPAIR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      POSE_REST   = 3'd0,
      POSE_FIST   = 3'd1,
      POSE_WAVEIN = 3'd2,
      POSE_WAVEOUT= 3'd3,
      POSE_SPREAD = 3'd4,
      POSE_DTAP   = 3'd5
   } pose_type;

   typedef enum logic [2:0] {
      CSR_YAW_INNER = 3'd0,
      CSR_YAW_OUTER = 3'd1,
      CSR_YAW_NEG   = 3'd2,
      CSR_PITCH     = 3'd3,
      CSR_ROLL_POS  = 3'd4,
      CSR_ROLL_NEG  = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_ROLL_SUM,
      ST_YAW_SUM,
      ST_PITCH_SUM,
      ST_SQRT,
      ST_CORDIC_INIT,
      ST_CORDIC,
      ST_CORDIC_DONE,
      ST_OFFSET,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic [2:0]         pose_code;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] roll_offset;
      logic signed [15:0] pitch_offset;
      logic signed [15:0] yaw_offset;
      logic [6:0]         letter_code;
   } rsp_word_type;

   function automatic logic [30:0] atan_q30(input logic [4:0] idx);
      logic [30:0] r;
      begin
         case (idx)
            5'd0:  r = 31'd843314857;
            5'd1:  r = 31'd497837829;
            5'd2:  r = 31'd263043836;
            5'd3:  r = 31'd133525158;
            5'd4:  r = 31'd67021686;
            5'd5:  r = 31'd33543515;
            5'd6:  r = 31'd16775850;
            5'd7:  r = 31'd8388437;
            5'd8:  r = 31'd4194282;
            5'd9:  r = 31'd2097149;
            5'd10: r = 31'd1048575;
            5'd11: r = 31'd524287;
            5'd12: r = 31'd262143;
            5'd13: r = 31'd131071;
            5'd14: r = 31'd65535;
            5'd15: r = 31'd32767;
            5'd16: r = 31'd16383;
            5'd17: r = 31'd8191;
            5'd18: r = 31'd4095;
            5'd19: r = 31'd2047;
            default: r = 31'd0;
         endcase
         return r;
      end
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [AccWidth-1:0] v);
      logic signed [15:0] r;
      begin
         if (v > 40'sd32767) r = 16'sh7fff;
         else if (v < -40'sd32768) r = -16'sh8000;
         else r = v[15:0];
         return r;
      end
   endfunction

endpackage

// ===== hw/rtl/quaternion_tilt_letter_classifier_core.sv =====
// Throughput: one word at a time; req_stall stays high from accept until the result word leaves.
// One shared multiplier forms the quaternion products, one shared CORDIC stage and a
// bit-serial square root (one root bit a cycle) produce the three angles.
// Reset (synchronous, active high) clears all angles, last pose and loads register defaults.
module quaternion_tilt_letter_classifier_core
   import qtlc_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = AngleFracBitsDefault,
   parameter int CORDIC_STEPS    = CordicStepsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_word_type              req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_word_type              rsp_word,
   input  logic                      csr_write,
   input  logic [CfgIndexWidth-1:0]  csr_index,
   input  logic [CfgWidth-1:0]       csr_data
);

   localparam int RoundShift = 30 - ANGLE_FRAC_BITS;
   localparam int StepWidth  = $clog2(CORDIC_STEPS + 1);

   state_type state_ff, state_in;
   req_word_type req_ff;

   logic [CfgWidth-1:0] lim_ff [6];

   logic signed [15:0] cur_ff [3];
   logic signed [15:0] ref_ff [3];
   logic signed [15:0] off_ff [3];
   logic [2:0]         pose_ff;
   rsp_word_type       rsp_ff;
   logic               rsp_valid_ff;

   // product sequencer: 10 products
   logic [3:0] pcnt_ff;
   logic signed [VecWidth-1:0] prod_ff [10];
   logic signed [15:0] ma, mb;
   logic signed [31:0] mprod;

   // vector inputs for the three angles: 0 roll, 1 pitch, 2 yaw
   logic signed [VecWidth-1:0] vy_ff [3];
   logic signed [VecWidth-1:0] vx_ff [3];
   logic [1:0] ang_ff;

   // square root
   logic [SqrtRadWidth-1:0]  rad_ff;
   logic [SqrtRootWidth-1:0] root_ff;
   logic [SqrtRadWidth-1:0]  rem_ff;
   logic [4:0]               scnt_ff;

   // cordic
   logic signed [VecWidth-1:0] cx_ff, cy_ff;
   logic signed [AccWidth-1:0] cacc_ff;
   logic [StepWidth-1:0]       ccnt_ff;
   logic                       czero_ff;

   logic req_fire;
   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff[0] <= 15'd2048;
         lim_ff[1] <= 15'd8192;
         lim_ff[2] <= 15'd3277;
         lim_ff[3] <= 15'd3277;
         lim_ff[4] <= 15'd8192;
         lim_ff[5] <= 15'd1434;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_YAW_INNER: lim_ff[0] <= csr_data;
            CSR_YAW_OUTER: lim_ff[1] <= csr_data;
            CSR_YAW_NEG:   lim_ff[2] <= csr_data;
            CSR_PITCH:     lim_ff[3] <= csr_data;
            CSR_ROLL_POS:  lim_ff[4] <= csr_data;
            CSR_ROLL_NEG:  lim_ff[5] <= csr_data;
            default: ;
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      ma = req_ff.quat_w;
      mb = req_ff.quat_x;
      case (pcnt_ff)
         4'd0: begin ma = req_ff.quat_w; mb = req_ff.quat_x; end
         4'd1: begin ma = req_ff.quat_y; mb = req_ff.quat_z; end
         4'd2: begin ma = req_ff.quat_x; mb = req_ff.quat_x; end
         4'd3: begin ma = req_ff.quat_y; mb = req_ff.quat_y; end
         4'd4: begin ma = req_ff.quat_w; mb = req_ff.quat_y; end
         4'd5: begin ma = req_ff.quat_z; mb = req_ff.quat_x; end
         4'd6: begin ma = req_ff.quat_w; mb = req_ff.quat_z; end
         4'd7: begin ma = req_ff.quat_x; mb = req_ff.quat_y; end
         4'd8: begin ma = req_ff.quat_z; mb = req_ff.quat_z; end
         default: begin ma = req_ff.quat_z; mb = req_ff.quat_z; end
      endcase
      mprod = ma * mb;
   end

   // classification
   function automatic logic [6:0] pick(input logic [2:0] p, input logic [6:0] sp,
                                       input logic [6:0] wi, input logic [6:0] wo,
                                       input logic [6:0] dt);
      logic [6:0] r;
      begin
         case (p)
            POSE_SPREAD:  r = sp;
            POSE_WAVEIN:  r = wi;
            POSE_WAVEOUT: r = wo;
            POSE_DTAP:    r = dt;
            default:      r = 7'd0;
         endcase
         return r;
      end
   endfunction

   logic [6:0] letter;
   always_comb begin
      logic signed [16:0] ro, po, yo, yin, yout, yneg, pl, rpos, rneg;
      ro   = 17'(off_ff[0]);
      po   = 17'(off_ff[1]);
      yo   = 17'(off_ff[2]);
      yin  = 17'($signed({2'b00, lim_ff[0]}));
      yout = 17'($signed({2'b00, lim_ff[1]}));
      yneg = -17'($signed({2'b00, lim_ff[2]}));
      pl   = 17'($signed({2'b00, lim_ff[3]}));
      rpos = 17'($signed({2'b00, lim_ff[4]}));
      rneg = -17'($signed({2'b00, lim_ff[5]}));
      if (yo > yin && yo < yout)      letter = pick(pose_ff, 7'd79, 7'd77, 7'd78, 7'd0);
      else if (yo < yneg)             letter = pick(pose_ff, 7'd71, 7'd73, 7'd72, 7'd10);
      else if (po > pl)               letter = pick(pose_ff, 7'd67, 7'd65, 7'd66, 7'd32);
      else if (po < -pl)              letter = pick(pose_ff, 7'd86, 7'd84, 7'd85, 7'd0);
      else if (ro > rpos)             letter = pick(pose_ff, 7'd70, 7'd68, 7'd69, 7'd0);
      else if (ro < rneg)             letter = pick(pose_ff, 7'd80, 7'd81, 7'd82, 7'd83);
      else if (yo < yin && yo > 0)    letter = pick(pose_ff, 7'd87, 7'd88, 7'd89, 7'd0);
      else if (yo < 0 && yo > yneg)
         letter = pick(pose_ff, 7'd90, 7'd74, 7'd75, (ro > rneg) ? 7'd76 : 7'd0);
      else letter = 7'd0;
   end

   // cordic step datapath (arithmetic shift is floor shift)
   logic signed [VecWidth-1:0] sh_x, sh_y, nx, ny;
   logic signed [AccWidth-1:0] nacc, rnd;
   logic [4:0] cidx;
   always_comb begin
      cidx = 5'(ccnt_ff);
      sh_x = cx_ff >>> cidx;
      sh_y = cy_ff >>> cidx;
      if (cy_ff > 0) begin
         nx   = cx_ff + sh_y;
         ny   = cy_ff - sh_x;
         nacc = cacc_ff + AccWidth'(atan_q30(cidx));
      end else begin
         nx   = cx_ff - sh_y;
         ny   = cy_ff + sh_x;
         nacc = cacc_ff - AccWidth'(atan_q30(cidx));
      end
      rnd = (cacc_ff + $signed(AccWidth'(1) << (RoundShift - 1))) >>> RoundShift;
   end

   // square root step
   logic [SqrtRadWidth-1:0] s_trial, s_rem;
   always_comb begin
      s_rem   = {rem_ff[SqrtRadWidth-3:0], rad_ff[SqrtRadWidth-1 -: 2]};
      s_trial = {SqrtRadWidth'(root_ff) << 2} | SqrtRadWidth'(1);
   end

   logic signed [VecWidth-1:0] s_clamp;
   logic [SqrtRootWidth-1:0]   s_mag;
   logic [SqrtRadWidth-1:0]    s_sq;
   always_comb begin
      logic signed [VecWidth-1:0] sv;
      sv = (prod_ff[4] - prod_ff[5]) <<< 1;
      if (sv > OneQ28) s_clamp = OneQ28;
      else if (sv < -OneQ28) s_clamp = -OneQ28;
      else s_clamp = sv;
      // |s| is at most 2^28, so the square needs only a 29 by 29 product
      s_mag = SqrtRootWidth'((s_clamp < 0) ? -s_clamp : s_clamp);
      s_sq  = SqrtRadWidth'(s_mag) * SqrtRadWidth'(s_mag);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:        if (req_fire) state_in = (kind_type'(req_word.kind) == KIND_SAMPLE)
                                                  ? ST_PROD : ST_OUT;
         ST_PROD:        if (pcnt_ff == 4'd9) state_in = ST_ROLL_SUM;
         ST_ROLL_SUM:    state_in = ST_YAW_SUM;
         ST_YAW_SUM:     state_in = ST_PITCH_SUM;
         ST_PITCH_SUM:   state_in = ST_SQRT;
         ST_SQRT:        if (scnt_ff == 5'(SqrtSteps - 1)) state_in = ST_CORDIC_INIT;
         ST_CORDIC_INIT: state_in = ST_CORDIC;
         ST_CORDIC:      if (ccnt_ff == StepWidth'(CORDIC_STEPS - 1)) state_in = ST_CORDIC_DONE;
         ST_CORDIC_DONE: state_in = (ang_ff == 2'd2) ? ST_OFFSET : ST_CORDIC_INIT;
         ST_OFFSET:      state_in = ST_IDLE;
         ST_OUT:         state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pose_ff      <= 3'd0;
         for (int i = 0; i < 3; i++) begin
            cur_ff[i] <= '0;
            ref_ff[i] <= '0;
            off_ff[i] <= '0;
         end
         pcnt_ff <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) req_ff <= req_word;
               pcnt_ff <= '0;
            end
            ST_PROD: begin
               prod_ff[pcnt_ff] <= VecWidth'(mprod);
               pcnt_ff <= pcnt_ff + 4'd1;
            end
            ST_ROLL_SUM: begin
               vy_ff[0] <= (prod_ff[0] + prod_ff[1]) <<< 1;
               vx_ff[0] <= OneQ28 - ((prod_ff[2] + prod_ff[3]) <<< 1);
            end
            ST_YAW_SUM: begin
               vy_ff[2] <= (prod_ff[6] + prod_ff[7]) <<< 1;
               vx_ff[2] <= OneQ28 - ((prod_ff[3] + prod_ff[8]) <<< 1);
            end
            ST_PITCH_SUM: begin
               // radicand is 2^56 - s*s, formed by one multiply of the clamped term
               vy_ff[1] <= s_clamp;
               rad_ff   <= (SqrtRadWidth'(1) << 56) - s_sq;
               root_ff  <= '0;
               rem_ff   <= '0;
               scnt_ff  <= '0;
               ang_ff   <= 2'd0;
            end
            ST_SQRT: begin
               rad_ff <= rad_ff << 2;
               if (s_rem >= s_trial) begin
                  rem_ff  <= s_rem - s_trial;
                  root_ff <= {root_ff[SqrtRootWidth-2:0], 1'b1};
               end else begin
                  rem_ff  <= s_rem;
                  root_ff <= {root_ff[SqrtRootWidth-2:0], 1'b0};
               end
               scnt_ff <= scnt_ff + 5'd1;
               if (scnt_ff == 5'(SqrtSteps - 1))
                  vx_ff[1] <= VecWidth'({1'b0, root_ff[SqrtRootWidth-2:0],
                                         (s_rem >= s_trial)});
            end
            ST_CORDIC_INIT: begin
               ccnt_ff  <= '0;
               czero_ff <= (vx_ff[ang_ff] == 0) && (vy_ff[ang_ff] == 0);
               if (vx_ff[ang_ff] < 0) begin
                  cacc_ff <= (vy_ff[ang_ff] >= 0) ? PiQ30 : -PiQ30;
                  cx_ff   <= -vx_ff[ang_ff];
                  cy_ff   <= -vy_ff[ang_ff];
               end else begin
                  cacc_ff <= '0;
                  cx_ff   <= vx_ff[ang_ff];
                  cy_ff   <= vy_ff[ang_ff];
               end
            end
            ST_CORDIC: begin
               cx_ff   <= nx;
               cy_ff   <= ny;
               cacc_ff <= nacc;
               ccnt_ff <= ccnt_ff + StepWidth'(1);
            end
            ST_CORDIC_DONE: begin
               cur_ff[ang_ff] <= czero_ff ? 16'sd0 : sat16(rnd);
               ang_ff <= ang_ff + 2'd1;
            end
            ST_OFFSET: begin
               for (int i = 0; i < 3; i++)
                  off_ff[i] <= sat16(AccWidth'(cur_ff[i]) - AccWidth'(ref_ff[i]));
               rsp_ff.roll_offset  <= sat16(AccWidth'(cur_ff[0]) - AccWidth'(ref_ff[0]));
               rsp_ff.pitch_offset <= sat16(AccWidth'(cur_ff[1]) - AccWidth'(ref_ff[1]));
               rsp_ff.yaw_offset   <= sat16(AccWidth'(cur_ff[2]) - AccWidth'(ref_ff[2]));
               rsp_ff.letter_code  <= 7'd0;
               rsp_valid_ff <= 1'b1;
            end
            ST_OUT: begin
               rsp_ff.roll_offset  <= off_ff[0];
               rsp_ff.pitch_offset <= off_ff[1];
               rsp_ff.yaw_offset   <= off_ff[2];
               rsp_ff.letter_code  <= 7'd0;
               unique case (kind_type'(req_ff.kind))
                  KIND_POSE: begin
                     pose_ff <= req_ff.pose_code;
                     if (req_ff.pose_code == POSE_FIST)
                        for (int i = 0; i < 3; i++) ref_ff[i] <= cur_ff[i];
                  end
                  KIND_REPORT: rsp_ff.letter_code <= letter;
                  KIND_UNPAIR: for (int i = 0; i < 3; i++) cur_ff[i] <= '0;
                  default: ;
               endcase
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

endmodule
